// ----- rtl/round_robin_slice_scheduler_defines.svh -----
// assertion macros shared by the scheduler modules
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk and disabled during rst
`define RRSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and disabled during rst
`define RRSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rrss_pkg.sv -----
// types and constants of the round-robin slice scheduler
package rrss_pkg;

  localparam int BURST_W = 16;
  localparam int QUANT_W = 8;
  localparam int CLOCK_W = 22;
  localparam int TIDX_W  = 6;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;
  localparam logic [CLOCK_W-1:0] CLOCK_MAX     = 22'h3F_FFFF;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // one task entry of the table
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] progress;
    logic               started;
    logic [CLOCK_W-1:0] start;
    logic               finished;
  } task_rec_t;

  // one result
  typedef struct packed {
    logic               idle;
    logic [TIDX_W-1:0]  task_index;
    logic [CLOCK_W-1:0] slice_start;
    logic [QUANT_W-1:0] slice_length;
    logic [BURST_W-1:0] done_so_far;
    logic               task_finished;
    logic [CLOCK_W-1:0] first_start;
    logic [CLOCK_W-1:0] wait_units;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept_load;
    logic accept_step;
    logic read;
    logic advance;
    logic calc1;
    logic calc2;
    logic calc3;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic none_open;
    logic cand_finished;
  } status_t;

endpackage

// ----- rtl/rrss_ifs.sv -----
// channel interfaces of the scheduler: request, grant and configuration

interface rrss_req_if;
  import rrss_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [BURST_W-1:0] burst;
  modport source (output valid, func, burst, input ready);
  modport sink   (input valid, func, burst, output ready);
endinterface

interface rrss_grant_if;
  import rrss_pkg::*;
  logic               valid;
  logic               ready;
  logic               idle;
  logic [TIDX_W-1:0]  task_index;
  logic [CLOCK_W-1:0] slice_start;
  logic [QUANT_W-1:0] slice_length;
  logic [BURST_W-1:0] done_so_far;
  logic               task_finished;
  logic [CLOCK_W-1:0] first_start;
  logic [CLOCK_W-1:0] wait_units;
  modport source (output valid, idle, task_index, slice_start, slice_length, done_so_far,
                  task_finished, first_start, wait_units, input ready);
  modport sink   (input valid, idle, task_index, slice_start, slice_length, done_so_far,
                  task_finished, first_start, wait_units, output ready);
endinterface

interface rrss_cfg_if;
  import rrss_pkg::*;
  logic               valid;
  logic               ready;
  logic [QUANT_W-1:0] quantum;
  modport source (output valid, quantum, input ready);
  modport sink   (input valid, quantum, output ready);
endinterface

// ----- rtl/rrss_ctrl.sv -----
// sequencing state machine of the scheduler
`include "round_robin_slice_scheduler_defines.svh"

module rrss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_func,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  rrss_pkg::status_t status,
  output rrss_pkg::cmd_t   cmd
);
  import rrss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_CALC1, S_CALC2, S_CALC3, S_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_func == FUNC_LOAD) begin
            cmd.accept_load = 1'b1;
          end else begin
            cmd.accept_step = 1'b1;
            state_next      = status.none_open ? S_EMIT : S_READ;
          end
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.cand_finished) begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end else begin
          state_next = S_CALC1;
        end
      end
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = S_CALC3;
      end
      S_CALC3: begin
        cmd.calc3  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `RRSS_ASSERT_NXT(a_idle_result_direct,
    state == S_IDLE && req_valid && req_func == FUNC_STEP && status.none_open,
    state == S_EMIT, "step with no open task must go straight to emit")
  `RRSS_ASSERT_NXT(a_open_cand_taken, state == S_CHECK && !status.cand_finished,
    state == S_CALC1, "unfinished candidate must be granted")
  `RRSS_ASSERT_IMP(a_no_overwrite, cmd.load_out, !rsp_valid || rsp_ready,
    "output register overwritten before its transfer")

endmodule

// ----- rtl/rrss_datapath.sv -----
// task table, clock, ring pointer and slice arithmetic of the scheduler
`include "round_robin_slice_scheduler_defines.svh"

module rrss_datapath #(
  parameter int MAX_TASKS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rrss_pkg::cmd_t            cmd,
  output rrss_pkg::status_t         status,
  input  logic [rrss_pkg::BURST_W-1:0] req_burst,
  input  logic                      cfg_valid,
  input  logic [rrss_pkg::QUANT_W-1:0] cfg_quantum,
  output rrss_pkg::result_t         rsp_data
);
  import rrss_pkg::*;

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int SUB_W  = ((IDX_W > BURST_W) ? IDX_W : BURST_W) + 1;
  localparam int WAIT_W = CLOCK_W + 1;

  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   open_count;
  logic               ring_valid;
  logic [IDX_W-1:0]   ring_ptr;
  logic [IDX_W-1:0]   cand;
  logic [CLOCK_W-1:0] clock_now;
  logic [QUANT_W-1:0] quantum;

  task_rec_t          task_mem [MAX_TASKS];
  task_rec_t          rec;

  logic [QUANT_W-1:0] add_r;
  logic [CLOCK_W-1:0] endt_r;
  logic [SUB_W-1:0]   sub_r;
  result_t            res_r;
  result_t            out_r;
  result_t            res_init;

  logic [CNT_W-1:0]   ptr_inc;
  logic [CNT_W-1:0]   cand_inc;
  logic [IDX_W-1:0]   base;
  logic [IDX_W-1:0]   cand_next;
  logic [QUANT_W-1:0] q_eff;
  logic [BURST_W-1:0] rest;
  logic [QUANT_W-1:0] add_calc;
  logic [BURST_W-1:0] prog_new;
  logic               fin;
  logic [WAIT_W-1:0]  clk_sum;
  logic [CLOCK_W-1:0] endt;
  logic [CLOCK_W-1:0] first;
  logic [IDX_W+TIDX_W-1:0] idx_ext;
  logic [SUB_W-1:0]   sub_calc;
  logic [WAIT_W-1:0]  endt_ext;
  logic [WAIT_W-1:0]  sub_ext;
  logic [WAIT_W-1:0]  wait_diff;
  logic [CLOCK_W-1:0] wait_val;
  logic               load_ok;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  task_rec_t          mem_wdata;

  // ring order: one past the last grant, wrapping at the task count
  assign ptr_inc   = CNT_W'(ring_ptr) + CNT_W'(1);
  assign cand_inc  = CNT_W'(cand) + CNT_W'(1);
  assign base      = (!ring_valid || ptr_inc == loaded_count) ? '0 : ptr_inc[IDX_W-1:0];
  assign cand_next = (cand_inc == loaded_count) ? '0 : cand_inc[IDX_W-1:0];

  // slice length, a zero quantum acts as one
  assign q_eff    = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign rest     = rec.burst - rec.progress;
  assign add_calc = (rest < BURST_W'(q_eff)) ? rest[QUANT_W-1:0] : q_eff;

  assign prog_new = rec.progress + BURST_W'(add_r);
  assign fin      = (prog_new == rec.burst);
  assign clk_sum  = {1'b0, clock_now} + WAIT_W'(add_r);
  assign endt     = clk_sum[CLOCK_W] ? CLOCK_MAX : clk_sum[CLOCK_W-1:0];
  assign first    = rec.started ? rec.start : clock_now;
  assign idx_ext  = {{TIDX_W{1'b0}}, cand};
  assign sub_calc = SUB_W'(rec.burst) + SUB_W'(cand);

  // waiting time clamps at zero
  assign endt_ext  = WAIT_W'(endt_r);
  assign sub_ext   = WAIT_W'(sub_r);
  assign wait_diff = endt_ext - sub_ext;
  assign wait_val  = (res_r.task_finished && endt_ext > sub_ext) ?
                     wait_diff[CLOCK_W-1:0] : '0;

  assign load_ok   = cmd.accept_load && (loaded_count < CNT_W'(MAX_TASKS));
  assign mem_we    = load_ok || cmd.calc2;
  assign mem_waddr = cmd.calc2 ? cand : loaded_count[IDX_W-1:0];

  // fresh result at the start of a step, idle when nothing is open
  always_comb begin
    res_init      = '0;
    res_init.idle = (open_count == '0);
  end

  always_comb begin
    if (cmd.calc2) begin
      mem_wdata.burst    = rec.burst;
      mem_wdata.progress = prog_new;
      mem_wdata.started  = 1'b1;
      mem_wdata.start    = first;
      mem_wdata.finished = fin;
    end else begin
      mem_wdata.burst    = req_burst;
      mem_wdata.progress = '0;
      mem_wdata.started  = 1'b0;
      mem_wdata.start    = '0;
      mem_wdata.finished = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      task_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rec <= task_mem[cand];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      open_count   <= '0;
      ring_valid   <= 1'b0;
      clock_now    <= '0;
      quantum      <= QUANTUM_RESET;
    end else begin
      if (cfg_valid) begin
        quantum <= cfg_quantum;
      end
      if (load_ok) begin
        loaded_count <= loaded_count + CNT_W'(1);
        open_count   <= open_count + CNT_W'(1);
      end
      if (cmd.calc2) begin
        ring_valid <= 1'b1;
        clock_now  <= endt;
        if (fin) begin
          open_count <= open_count - CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept_step) begin
      cand  <= base;
      res_r <= res_init;
    end
    if (cmd.advance) begin
      cand <= cand_next;
    end
    if (cmd.calc1) begin
      add_r <= add_calc;
    end
    if (cmd.calc2) begin
      ring_ptr             <= cand;
      res_r.task_index     <= idx_ext[TIDX_W-1:0];
      res_r.slice_start    <= clock_now;
      res_r.slice_length   <= add_r;
      res_r.done_so_far    <= prog_new;
      res_r.task_finished  <= fin;
      res_r.first_start    <= fin ? first : '0;
      endt_r               <= endt;
      sub_r                <= sub_calc;
    end
    if (cmd.calc3) begin
      res_r.wait_units <= wait_val;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign status.none_open     = (open_count == '0);
  assign status.cand_finished = rec.finished;
  assign rsp_data             = out_r;

  `RRSS_ASSERT_IMP(a_open_bounded, 1'b1, open_count <= loaded_count,
    "more open tasks than loaded tasks")
  `RRSS_ASSERT_NXT(a_finish_closes, cmd.calc2 && fin,
    open_count == $past(open_count) - CNT_W'(1), "finished task not removed from open count")
  `RRSS_ASSERT_IMP(a_cand_in_table, cmd.read, CNT_W'(cand) < loaded_count,
    "candidate outside the loaded tasks")

endmodule

// ----- rtl/round_robin_slice_scheduler.sv -----
// top level of the round-robin slice scheduler
//
// Round-robin scheduler with a fixed quantum over a table of up to MAX_TASKS tasks. A
// request transfer with func 0 appends a task (its arrival time is its load index);
// it gives no result, and it is dropped when the table is full. A
// request with func 1 grants one slice of min(quantum, remaining) time units to the next
// unfinished task in ring order after the last one granted, starting at the running clock
// (which saturates at 2^22-1), and gives one grant transfer; when no task is open the
// grant reports idle with all other fields zero. An idle step goes from accept straight to
// emit; a granted step runs the ring search, three arithmetic states and emit. The task
// table is a single-port memory with registered read data, so the ring search reads each
// entry, then checks it, skipping every finished task on the way round the ring. A finished
// result sits in an output register, so the next request is taken while it waits. The
// quantum register (reset 4, a value of 0 acts as 1) is written through the cfg channel,
// which is always ready, and must only be written while the block is idle.

module round_robin_slice_scheduler #(
  parameter int MAX_TASKS = 64
) (
  input  logic       clk,
  input  logic       rst,
  rrss_req_if.sink   request,
  rrss_grant_if.source grant,
  rrss_cfg_if.sink   cfg
);
  import rrss_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t rsp_data;
  logic    rsp_valid;

  // configuration register takes every transfer
  assign cfg.ready = 1'b1;

  // sequencing: accept, ring search, three arithmetic steps, emit
  rrss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_func  (request.func),
    .req_ready (request.ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (grant.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // task table memory, clock, ring pointer and result registers
  rrss_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .req_burst   (request.burst),
    .cfg_valid   (cfg.valid),
    .cfg_quantum (cfg.quantum),
    .rsp_data    (rsp_data)
  );

  // grant channel payload straight from the output register
  assign grant.valid         = rsp_valid;
  assign grant.idle          = rsp_data.idle;
  assign grant.task_index    = rsp_data.task_index;
  assign grant.slice_start   = rsp_data.slice_start;
  assign grant.slice_length  = rsp_data.slice_length;
  assign grant.done_so_far   = rsp_data.done_so_far;
  assign grant.task_finished = rsp_data.task_finished;
  assign grant.first_start   = rsp_data.first_start;
  assign grant.wait_units    = rsp_data.wait_units;

endmodule

// ----- verif/round_robin_slice_scheduler_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the round-robin slice scheduler with its own slice predictor

module round_robin_slice_scheduler_test;
  import rrss_pkg::*;

  localparam int MAX_TASKS     = 64;
  // worst quiet stretch: the long receiver hold-off, a full ring search and a settle pause
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 300;
  // a load gives no grant, so allow it to retire before touching the quantum
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 50;
  localparam int PRINT_CAP     = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  rrss_req_if   request ();
  rrss_grant_if grant ();
  rrss_cfg_if   cfg ();

  round_robin_slice_scheduler #(
    .MAX_TASKS(MAX_TASKS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .grant  (grant),
    .cfg    (cfg)
  );

  // ---------------------------------------------------------------------------------------
  // slice predictor state: our own copy of the task table, ring position and clock
  // ---------------------------------------------------------------------------------------
  logic [BURST_W-1:0] tbl_burst   [MAX_TASKS];
  logic [BURST_W-1:0] tbl_done    [MAX_TASKS];
  logic [CLOCK_W-1:0] tbl_first   [MAX_TASKS];
  bit                 tbl_started [MAX_TASKS];
  bit                 tbl_closed  [MAX_TASKS];
  int                 n_tasks      = 0;
  bit                 have_last    = 1'b0;
  int                 last_granted = 0;
  int unsigned        sched_clock  = 0;
  logic [QUANT_W-1:0] quantum_reg  = QUANTUM_RESET;

  // grants still owed by the block, oldest first
  result_t grants_due [$];

  // bookkeeping
  int mismatch_count = 0;
  int grants_checked = 0;
  int finished_seen  = 0;
  int idle_seen      = 0;
  int loads_taken    = 0;
  int steps_taken    = 0;
  int no_gap_left    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // works out what one accepted request does to the table and queues the grant it owes
  function automatic void predict_request(input logic f, input logic [BURST_W-1:0] b);
    result_t     r;
    int          pick, pos, k;
    int unsigned q, rest, add, endt, sub;
    bit          found;
    if (f == FUNC_LOAD) begin
      loads_taken++;
      // a full table silently drops the load
      if (n_tasks < MAX_TASKS) begin
        tbl_burst[n_tasks]   = b;
        tbl_done[n_tasks]    = '0;
        tbl_first[n_tasks]   = '0;
        tbl_started[n_tasks] = 1'b0;
        tbl_closed[n_tasks]  = 1'b0;
        n_tasks++;
      end
      return;
    end
    steps_taken++;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    // ring search starts just after the last task granted, or at entry 0 before any grant
    for (k = 0; k < n_tasks && !found; k++) begin
      pos = ((have_last ? last_granted + 1 : 0) + k) % n_tasks;
      if (!tbl_closed[pos]) begin
        pick  = pos;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.idle = 1'b1;
      grants_due.push_back(r);
      return;
    end
    have_last    = 1'b1;
    last_granted = pick;
    // a quantum of zero behaves as one
    q    = (quantum_reg == '0) ? 1 : quantum_reg;
    rest = tbl_burst[pick] - tbl_done[pick];
    add  = (rest < q) ? rest : q;
    tbl_done[pick] = tbl_done[pick] + BURST_W'(add);
    if (!tbl_started[pick]) begin
      tbl_started[pick] = 1'b1;
      tbl_first[pick]   = CLOCK_W'(sched_clock);
    end
    r.task_index   = TIDX_W'(pick);
    r.slice_start  = CLOCK_W'(sched_clock);
    r.slice_length = QUANT_W'(add);
    r.done_so_far  = tbl_done[pick];
    // the running clock saturates rather than wrapping
    endt = sched_clock + add;
    if (endt > CLOCK_MAX)
      endt = CLOCK_MAX;
    sched_clock = endt;
    if (tbl_done[pick] == tbl_burst[pick]) begin
      tbl_closed[pick] = 1'b1;
      r.task_finished  = 1'b1;
      r.first_start    = tbl_first[pick];
      // waiting time is end - burst - arrival, clamped at zero when that goes negative
      sub = tbl_burst[pick] + pick;
      r.wait_units = (endt > sub) ? CLOCK_W'(endt - sub) : '0;
    end
    grants_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------------------
  // mismatch reporting: one line each, capped so a broken block cannot flood the log
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t ns: grant %0d: %s is %0d, predicted %0d", $time, grants_checked, what,
               got, want);
  endtask

  // ---------------------------------------------------------------------------------------
  // request side: gap choice and the one task that moves a request transfer
  // ---------------------------------------------------------------------------------------

  // mostly back to back or short gaps, a few long ones, now and then a gapless stretch
  function automatic int pick_gap();
    int roll;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      no_gap_left = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 50)
      return 0;
    if (roll < 93)
      return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  // burst lengths: mostly short tasks that finish, some medium, some up to the full range
  function automatic logic [BURST_W-1:0] random_burst();
    int roll;
    roll = $urandom_range(99);
    if (roll < 2)
      return '0;
    if (roll < 50)
      return BURST_W'($urandom_range(64, 1));
    if (roll < 80)
      return BURST_W'($urandom_range(2000, 65));
    return BURST_W'($urandom);
  endfunction

  // valid stays high after the transfer; the next call or release_request moves it
  task automatic send_request(input logic f, input logic [BURST_W-1:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request.valid <= 1'b1;
    request.func  <= f;
    request.burst <= b;
    do @(posedge clk); while (!request.ready);
    predict_request(f, b);
  endtask

  task automatic release_request();
    @(negedge clk);
    request.valid <= 1'b0;
  endtask

  // quantum writes only with the block drained and quiet
  task automatic write_quantum(input logic [QUANT_W-1:0] q);
    release_request();
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg.valid   <= 1'b1;
    cfg.quantum <= q;
    do @(posedge clk); while (!cfg.ready);
    quantum_reg = q;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // grant side: ready pattern, with a long hold-off counted here when a test asks for one
  // ---------------------------------------------------------------------------------------
  initial begin
    int run_left;
    int roll;
    bit run_ready;
    grant.ready = 1'b0;
    run_left    = 0;
    run_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        grant.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          roll = $urandom_range(99);
          if (roll < 55) begin
            run_ready = 1'b1;
            run_left  = $urandom_range(40, 1);
          end else if (roll < 90) begin
            run_ready = 1'b0;
            run_left  = $urandom_range(3, 1);
          end else if (roll < 97) begin
            run_ready = 1'b0;
            run_left  = $urandom_range(10, 4);
          end else begin
            run_ready = 1'b0;
            run_left  = $urandom_range(60, 20);
          end
        end
        run_left--;
        grant.ready <= run_ready;
      end
    end
  end

  // each grant transfer against the oldest prediction, field by field
  always @(posedge clk) begin : check_grants
    result_t seen;
    result_t want;
    if (!rst && grant.valid && grant.ready) begin
      seen.idle          = grant.idle;
      seen.task_index    = grant.task_index;
      seen.slice_start   = grant.slice_start;
      seen.slice_length  = grant.slice_length;
      seen.done_so_far   = grant.done_so_far;
      seen.task_finished = grant.task_finished;
      seen.first_start   = grant.first_start;
      seen.wait_units    = grant.wait_units;
      grants_checked++;
      if (grants_due.size() == 0) begin
        report_mismatch("grant with nothing owed, task_index", seen.task_index, 0);
      end else begin
        want = grants_due.pop_front();
        if (want.idle)
          idle_seen++;
        if (want.task_finished)
          finished_seen++;
        if (seen.idle !== want.idle)
          report_mismatch("idle", seen.idle, want.idle);
        if (seen.task_index !== want.task_index)
          report_mismatch("task_index", seen.task_index, want.task_index);
        if (seen.slice_start !== want.slice_start)
          report_mismatch("slice_start", seen.slice_start, want.slice_start);
        if (seen.slice_length !== want.slice_length)
          report_mismatch("slice_length", seen.slice_length, want.slice_length);
        if (seen.done_so_far !== want.done_so_far)
          report_mismatch("done_so_far", seen.done_so_far, want.done_so_far);
        if (seen.task_finished !== want.task_finished)
          report_mismatch("task_finished", seen.task_finished, want.task_finished);
        if (seen.first_start !== want.first_start)
          report_mismatch("first_start", seen.first_start, want.first_start);
        if (seen.wait_units !== want.wait_units)
          report_mismatch("wait_units", seen.wait_units, want.wait_units);
      end
    end
  end

  // watchdog: too long without any transfer on any channel ends the run
  always @(posedge clk) begin
    if ((request.valid && request.ready) || (grant.valid && grant.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // slice requests before any load: idle grants, ring stays unselected
  task automatic test_empty_table();
    send_request(FUNC_STEP, '1);
    send_request(FUNC_STEP, '0);
    release_request();
  endtask

  // a zero-length task gets a zero slice and finishes on it, then nothing is left open
  task automatic test_zero_burst();
    send_request(FUNC_LOAD, '0);
    send_request(FUNC_STEP, '0);
    send_request(FUNC_STEP, '1);
    release_request();
  endtask

  // quantum of zero, full quantum and one; longest burst, a one-unit task finishing early
  // enough that its waiting time clamps at zero, and a load after slices have been handed out
  task automatic test_quantum_extremes();
    write_quantum('0);
    send_request(FUNC_LOAD, '1);
    send_request(FUNC_LOAD, BURST_W'(1));
    send_request(FUNC_LOAD, BURST_W'(16'hA5A5));
    repeat (3) send_request(FUNC_STEP, BURST_W'($urandom));
    write_quantum('1);
    repeat (3) send_request(FUNC_STEP, BURST_W'($urandom));
    send_request(FUNC_LOAD, BURST_W'(3));
    repeat (2) send_request(FUNC_STEP, BURST_W'($urandom));
    write_quantum(QUANT_W'(1));
    send_request(FUNC_STEP, BURST_W'(16'h5A5A));
    release_request();
  endtask

  // random mix of loads and slice requests under one quantum; once the table is full,
  // loads become rare and are simply dropped
  task automatic test_random_traffic(input logic [QUANT_W-1:0] q, input int count);
    int   k;
    logic f;
    write_quantum(q);
    for (k = 0; k < count; k++) begin
      f = ($urandom_range(99) < ((n_tasks < MAX_TASKS) ? 20 : 4)) ? FUNC_LOAD : FUNC_STEP;
      send_request(f, (f == FUNC_LOAD) ? random_burst() : BURST_W'($urandom));
    end
    release_request();
  endtask

  // receiver holds off for a long stretch while slice requests keep coming, so the
  // output register fills and the request side has to stall
  task automatic test_output_backpressure();
    hold_left = LONG_HOLD;
    repeat (24) send_request(FUNC_STEP, BURST_W'($urandom));
    release_request();
  endtask

  initial begin
    request.valid = 1'b0;
    request.func  = FUNC_LOAD;
    request.burst = '0;
    cfg.valid     = 1'b0;
    cfg.quantum   = QUANTUM_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_zero_burst();
    test_quantum_extremes();
    // back to the reset quantum first, then the extremes and a couple of random values
    test_random_traffic(QUANTUM_RESET, 400);
    test_random_traffic(QUANT_W'(1), 300);
    test_random_traffic(QUANT_W'($urandom_range(254, 2)), 300);
    test_output_backpressure();
    test_random_traffic('0, 300);
    test_random_traffic(QUANT_W'($urandom_range(254, 2)), 350);
    test_random_traffic('1, 300);

    // drain, then leave room for anything the block should not have sent
    while (grants_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d loads, %0d slice requests), %0d tasks in the table",
             loads_taken + steps_taken, loads_taken, steps_taken, n_tasks);
    $display("checked %0d grants (%0d finishing a task, %0d idle), quanta 0, 1, 4, 255 and random",
             grants_checked, finished_seen, idle_seen);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rrss_pkg.sv
rtl/rrss_ifs.sv
rtl/rrss_ctrl.sv
rtl/rrss_datapath.sv
rtl/round_robin_slice_scheduler.sv
verif/round_robin_slice_scheduler_test.sv
